// ===== sv/pip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// Shared sizes, command codes and sequencer states of the even-odd
// point-in-polygon tester.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_WIDTH  = 16;

    localparam int IDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * DIFF_W;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_J,
        ST_EDGE,
        ST_MUL_R,
        ST_CMP,
        ST_DONE
    } state_t;

endpackage

// ===== sv/point_in_polygon_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Vertex store with append / clear, and an even-odd ray-casting query that
// walks the stored edges through one shared multiplier.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | command, coord_x, coord_y
//  out     | out_valid / out_stall| inside_res, polygon_ready, vertex_overflow
//
//  Append and clear are done in the idle state. A query walks every stored
//  edge before its word is loaded; the one multiplier forms both cross
//  products of a straddling edge in turn.
//  The vertex memory is read at one address a cycle with registered data.
//  rst_n clears count, overflow flag, sequencer and output valid; the memory
//  itself is not cleared. A stalled output word holds; a new item is taken
//  while it waits, and a finished query waits in turn for the output register.
//
module point_in_polygon_test (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [1:0]                              command,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0]  coord_x,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0]  coord_y,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic                                    inside_res,
    output logic                                    polygon_ready,
    output logic                                    vertex_overflow
);

    localparam int W  = pip_pkg::COORD_WIDTH;
    localparam int IW = pip_pkg::IDX_W;
    localparam int CW = pip_pkg::CNT_W;
    localparam int DW = pip_pkg::DIFF_W;
    localparam int PW = pip_pkg::PROD_W;

    logic signed [W-1:0] mem_x [pip_pkg::MAX_VERTICES];
    logic signed [W-1:0] mem_y [pip_pkg::MAX_VERTICES];

    pip_pkg::state_t state_reg, state_next;

    logic [CW-1:0]       count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [IW-1:0]       last_reg, last_next;
    logic signed [W-1:0] px_reg, px_next;
    logic signed [W-1:0] py_reg, py_next;
    logic signed [W-1:0] xj_reg, xj_next;
    logic signed [W-1:0] yj_reg, yj_next;
    logic signed [W-1:0] rd_x_reg, rd_y_reg;
    logic signed [PW-1:0] lhs_reg, lhs_next;
    logic signed [PW-1:0] rhs_reg, rhs_next;
    logic                inside_reg, inside_next;

    logic                out_valid_reg, out_valid_next;
    logic                res_inside_reg, res_inside_next;
    logic                res_ready_reg, res_ready_next;
    logic                res_ovf_reg, res_ovf_next;

    logic                rd_en;
    logic [IW-1:0]       rd_addr;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;

    logic                accept;
    logic                out_free;
    logic [CW-1:0]       cnt_m1;
    logic                straddle;
    logic                up;
    logic                left;
    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] product;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign cnt_m1   = count_reg - CW'(1);
    assign wr_addr  = count_reg[IW-1:0];

    // Edge (j -> i) with i in the read register and j held aside.
    assign straddle = (rd_y_reg > py_reg) != (yj_reg > py_reg);
    assign up       = yj_reg > rd_y_reg;
    assign left     = up ? (lhs_reg < rhs_reg) : (lhs_reg > rhs_reg);
    assign product  = mul_a * mul_b;

    assign in_stall        = (state_reg != pip_pkg::ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign inside_res      = res_inside_reg;
    assign polygon_ready   = res_ready_reg;
    assign vertex_overflow = res_ovf_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= coord_x;
            mem_y[wr_addr] <= coord_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_x_reg <= mem_x[rd_addr];
            rd_y_reg <= mem_y[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pip_pkg::ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        last_reg       <= last_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        xj_reg         <= xj_next;
        yj_reg         <= yj_next;
        lhs_reg        <= lhs_next;
        rhs_reg        <= rhs_next;
        inside_reg     <= inside_next;
        res_inside_reg <= res_inside_next;
        res_ready_reg  <= res_ready_next;
        res_ovf_reg    <= res_ovf_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        idx_next        = idx_reg;
        last_next       = last_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        xj_next         = xj_reg;
        yj_next         = yj_reg;
        lhs_next        = lhs_reg;
        rhs_next        = rhs_reg;
        inside_next     = inside_reg;
        res_inside_next = res_inside_reg;
        res_ready_next  = res_ready_reg;
        res_ovf_next    = res_ovf_reg;
        out_valid_next  = out_valid_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        wr_en           = 1'b0;
        mul_a           = {px_reg[W-1], px_reg} - {rd_x_reg[W-1], rd_x_reg};
        mul_b           = {yj_reg[W-1], yj_reg} - {rd_y_reg[W-1], rd_y_reg};

        // drop the output word once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            pip_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        pip_pkg::CMD_APPEND:
                        begin
                            if (count_reg == CW'(pip_pkg::MAX_VERTICES))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        pip_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        pip_pkg::CMD_QUERY:
                        begin
                            px_next     = coord_x;
                            py_next     = coord_y;
                            inside_next = 1'b0;
                            idx_next    = '0;
                            last_next   = cnt_m1[IW-1:0];
                            if (count_reg == '0)
                            begin
                                state_next = pip_pkg::ST_DONE;
                            end
                            else
                            begin
                                // fetch the last vertex first: it closes the ring
                                rd_en      = 1'b1;
                                rd_addr    = cnt_m1[IW-1:0];
                                state_next = pip_pkg::ST_LOAD_J;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            pip_pkg::ST_LOAD_J:
            begin
                xj_next    = rd_x_reg;
                yj_next    = rd_y_reg;
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = pip_pkg::ST_EDGE;
            end
            pip_pkg::ST_EDGE:
            begin
                if (straddle)
                begin
                    lhs_next   = product;
                    state_next = pip_pkg::ST_MUL_R;
                end
                else
                begin
                    xj_next = rd_x_reg;
                    yj_next = rd_y_reg;
                    if (idx_reg == last_reg)
                    begin
                        state_next = pip_pkg::ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + IW'(1);
                    end
                end
            end
            pip_pkg::ST_MUL_R:
            begin
                mul_a      = {xj_reg[W-1], xj_reg} - {rd_x_reg[W-1], rd_x_reg};
                mul_b      = {py_reg[W-1], py_reg} - {rd_y_reg[W-1], rd_y_reg};
                rhs_next   = product;
                state_next = pip_pkg::ST_CMP;
            end
            pip_pkg::ST_CMP:
            begin
                if (left)
                begin
                    inside_next = !inside_reg;
                end
                xj_next = rd_x_reg;
                yj_next = rd_y_reg;
                if (idx_reg == last_reg)
                begin
                    state_next = pip_pkg::ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg + IW'(1);
                    state_next = pip_pkg::ST_EDGE;
                end
            end
            pip_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    res_inside_next = inside_reg;
                    res_ready_next  = (count_reg >= CW'(3));
                    res_ovf_next    = ovf_reg;
                    out_valid_next  = 1'b1;
                    state_next      = pip_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pip_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the even-odd point-in-polygon tester. Builds
// polygons on coarse grids (so points hit vertices, edges and horizontal
// runs), queries them, overflows the store, and mixes in noise words. An
// in-bench predictor mirrors the vertex store and scores every result word.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int         COORD_WIDTH  = pip_pkg::COORD_WIDTH;
    localparam int         MAX_VERTICES = pip_pkg::MAX_VERTICES;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RAND_WORDS   = 750;
    localparam int         TAIL_CYCLES  = 250;
    localparam longint     LIMIT        = 1_500_000;

    typedef struct {
        logic [1:0]                     cmd;
        logic signed [COORD_WIDTH-1:0]  x;
        logic signed [COORD_WIDTH-1:0]  y;
    } pip_word_t;

    typedef struct {
        bit in_poly;
        bit ready;
        bit ovf;
    } verdict_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    logic [1:0]                     command   = pip_pkg::CMD_APPEND;
    logic signed [COORD_WIDTH-1:0]  coord_x   = '0;
    logic signed [COORD_WIDTH-1:0]  coord_y   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic                           inside_res;
    logic                           polygon_ready;
    logic                           vertex_overflow;

    // predictor copy of the vertex store
    logic signed [COORD_WIDTH-1:0]  poly_x [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0]  poly_y [MAX_VERTICES];
    int                             poly_len     = 0;
    bit                             dropped_flag = 1'b0;

    pip_word_t  word_q    [$];
    verdict_t   verdict_q [$];
    pip_word_t  cur_word;
    verdict_t   got_v;
    verdict_t   want_v;

    int     gap_left   = 0;
    int     hold_left  = 0;
    int     tx_mode    = 1;
    int     rx_mode    = 1;
    int     errors     = 0;
    int     n_append   = 0;
    int     n_query    = 0;
    int     n_clear    = 0;
    int     n_unused   = 0;
    int     n_checked  = 0;
    int     n_in       = 0;
    int     n_ovf_seen = 0;
    int     planned    = 0;
    longint cycle_cnt  = 0;

    point_in_polygon_test u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .coord_x         (coord_x),
        .coord_y         (coord_y),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .inside_res      (inside_res),
        .polygon_ready   (polygon_ready),
        .vertex_overflow (vertex_overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, verdict_q.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Even-odd ray cast over the stored edges, exact integer cross products.
    function automatic bit ray_parity(input logic signed [COORD_WIDTH-1:0] px,
                                      input logic signed [COORD_WIDTH-1:0] py);
        bit     odd;
        int     prev;
        longint xa, ya, xb, yb, dy, lhs, rhs;
        bit     left;
        odd  = 1'b0;
        prev = poly_len - 1;
        for (int k = 0; k < poly_len; k++)
        begin
            xa = longint'(poly_x[k]);
            ya = longint'(poly_y[k]);
            xb = longint'(poly_x[prev]);
            yb = longint'(poly_y[prev]);
            if ((ya > longint'(py)) != (yb > longint'(py)))
            begin
                dy   = yb - ya;
                lhs  = (longint'(px) - xa) * dy;
                rhs  = (xb - xa) * (longint'(py) - ya);
                left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
                if (left)
                    odd = !odd;
            end
            prev = k;
        end
        return odd;
    endfunction

    function automatic void apply_word(input pip_word_t w);
        verdict_t v;
        case (w.cmd)
            pip_pkg::CMD_APPEND:
            begin
                n_append++;
                if (poly_len < MAX_VERTICES)
                begin
                    poly_x[poly_len] = w.x;
                    poly_y[poly_len] = w.y;
                    poly_len++;
                end
                else
                    dropped_flag = 1'b1;
            end
            pip_pkg::CMD_CLEAR:
            begin
                n_clear++;
                poly_len     = 0;
                dropped_flag = 1'b0;
            end
            pip_pkg::CMD_QUERY:
            begin
                n_query++;
                v.in_poly = ray_parity(w.x, w.y);
                v.ready   = (poly_len >= 3);
                v.ovf     = dropped_flag;
                verdict_q = {verdict_q, v};
            end
            default:
                n_unused++;
        endcase
    endfunction

    // Idle run length: mode 0 never idles, mode 1 mostly short, mode 2 bursty.
    function automatic int idle_len(input int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0:       return 0;
            1:       return (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3)
                                                    : $urandom_range(10, 40);
            default: return (r < 40) ? 0 : (r < 85) ? $urandom_range(1, 4)
                                                    : $urandom_range(8, 60);
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left  = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                apply_word(cur_word);
                if ((n_append + n_query + n_clear + n_unused) % 50 == 0)
                    tx_mode = $urandom_range(0, 2);
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (word_q.size() > 0)
                begin
                    cur_word = word_q.pop_front();
                    command  <= cur_word.cmd;
                    coord_x  <= cur_word.x;
                    coord_y  <= cur_word.y;
                    in_valid <= 1'b1;
                    gap_left  = idle_len(tx_mode);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    function automatic void check_bit(input string name, input bit want, input bit got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, want, got);
        end
    endfunction

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got_v.in_poly = inside_res;
                got_v.ready   = polygon_ready;
                got_v.ovf     = vertex_overflow;
                if (verdict_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word, actual in=%0b ready=%0b ovf=%0b",
                             $time, got_v.in_poly, got_v.ready, got_v.ovf);
                end
                else
                begin
                    want_v = verdict_q.pop_front();
                    check_bit("inside_res", want_v.in_poly, got_v.in_poly);
                    check_bit("polygon_ready", want_v.ready, got_v.ready);
                    check_bit("vertex_overflow", want_v.ovf, got_v.ovf);
                    n_checked++;
                    n_in       += want_v.in_poly;
                    n_ovf_seen += want_v.ovf;
                end
            end
            if (cycle_cnt % 700 == 0)
                rx_mode = $urandom_range(0, 2);
            if (hold_left > 0)
                hold_left--;
            else
            begin
                hold_left = idle_len(rx_mode);
                if (hold_left > 0)
                begin
                    out_stall <= 1'b1;
                    hold_left--;
                end
                else
                    out_stall <= 1'b0;
            end
        end
    end

    function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(input int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[COORD_WIDTH-1:0];
    endfunction

    function automatic void push_word(input logic [1:0] cmd, input int x, input int y);
        pip_word_t w;
        w.cmd  = cmd;
        w.x    = clamp_coord(x);
        w.y    = clamp_coord(y);
        word_q = {word_q, w};
        if (cmd != CMD_UNUSED)
            planned++;
    endfunction

    function automatic int full_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // Polygon on a grid around a random center (random vertices when a size is forced), then a burst of queries.
    function automatic void add_sequence(input int force_n);
        int cx, cy, step, span, n, q, r, px, py;
        cx   = full_coord();
        cy   = full_coord();
        step = ($urandom_range(0, 9) == 0) ? 4096 : $urandom_range(1, 64);
        span = $urandom_range(2, 8);
        if (force_n >= 0 || $urandom_range(0, 9) != 0)
            push_word(pip_pkg::CMD_CLEAR, full_coord(), full_coord());
        r = $urandom_range(0, 99);
        if (force_n >= 0)
            n = force_n;
        else if (r < 8)
            n = $urandom_range(0, 2);
        else if (r < 85)
            n = $urandom_range(3, 10);
        else if (r < 95)
            n = $urandom_range(11, 40);
        else
            n = $urandom_range(55, 70);
        for (int k = 0; k < n; k++)
        begin
            if (force_n >= 0)
                push_word(pip_pkg::CMD_APPEND, full_coord(), full_coord());
            else
                push_word(pip_pkg::CMD_APPEND,
                          cx + step * ($urandom_range(0, 2 * span) - span),
                          cy + step * ($urandom_range(0, 2 * span) - span));
        end
        q = $urandom_range(2, 8);
        for (int k = 0; k < q; k++)
        begin
            r  = $urandom_range(0, 99);
            px = cx + step * ($urandom_range(0, 2 * span + 2) - span - 1);
            py = cy + step * ($urandom_range(0, 2 * span + 2) - span - 1);
            if (r >= 90)
            begin
                px = full_coord();
                py = full_coord();
            end
            else if (r >= 70)
            begin
                px += $urandom_range(0, 2 * step) - step;
                py += $urandom_range(0, 2 * step) - step;
            end
            push_word(pip_pkg::CMD_QUERY, px, py);
        end
        if ($urandom_range(0, 19) == 0)
            push_word(CMD_UNUSED, full_coord(), full_coord());
    endfunction

    function automatic void add_noise();
        int n;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++)
            push_word(2'($urandom_range(0, 3)), full_coord(), full_coord());
    endfunction

    function automatic void add_random(input int upto);
        while (planned < upto)
        begin
            if ($urandom_range(0, 99) < 85)
                add_sequence(-1);
            else
                add_noise();
        end
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (word_q.size() != 0 || in_valid || verdict_q.size() != 0);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty store, then one and two vertices at the coordinate extremes
        push_word(pip_pkg::CMD_QUERY, 0, 0);
        push_word(pip_pkg::CMD_APPEND, -32768, -32768);
        push_word(pip_pkg::CMD_QUERY, -32768, -32768);
        push_word(pip_pkg::CMD_APPEND, 32767, 32767);
        push_word(pip_pkg::CMD_QUERY, 0, 0);
        // full-range triangle: inside, on a vertex, at a far corner
        push_word(pip_pkg::CMD_APPEND, 32767, -32768);
        push_word(pip_pkg::CMD_QUERY, 20000, -10000);
        push_word(pip_pkg::CMD_QUERY, 32767, 32767);
        push_word(pip_pkg::CMD_QUERY, -32768, 32767);
        push_word(CMD_UNUSED, -1, -1);
        // square with horizontal edges: center, on each side
        push_word(pip_pkg::CMD_CLEAR, 0, 0);
        push_word(pip_pkg::CMD_APPEND, 0, 0);
        push_word(pip_pkg::CMD_APPEND, 100, 0);
        push_word(pip_pkg::CMD_APPEND, 100, 100);
        push_word(pip_pkg::CMD_APPEND, 0, 100);
        push_word(pip_pkg::CMD_QUERY, 50, 50);
        push_word(pip_pkg::CMD_QUERY, 0, 50);
        push_word(pip_pkg::CMD_QUERY, 100, 50);
        push_word(pip_pkg::CMD_QUERY, 50, 0);
        push_word(pip_pkg::CMD_QUERY, 50, 100);
        push_word(pip_pkg::CMD_CLEAR, -1, -1);
        push_word(pip_pkg::CMD_QUERY, 50, 50);
        wait_drained();

        planned = 0;
        add_sequence(MAX_VERTICES + 2);
        add_random(RAND_WORDS / 2);
        // hold the sender until every pending result is back
        wait_drained();
        add_random(RAND_WORDS);
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (verdict_q.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, verdict_q.size());
        end
        $display("run covered %0d appends, %0d queries, %0d clears, %0d unused-code words",
                 n_append, n_query, n_clear, n_unused);
        $display("%0d results scored: %0d inside, %0d after a dropped vertex, %0d errors",
                 n_checked, n_in, n_ovf_seen, errors);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pip_pkg.sv
sv/point_in_polygon_test.sv
tb/sv/tb_top.sv
